/* hdl/bfr_pkg.sv */
// Shared types and constants for the bitmap font text renderer.
package bfr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF    = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_BYTES  = 3'd5;

  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_PRINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;
  // Widest store index over the parameter range
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned ROW_CNT_W  = 6;

  typedef struct packed {
    logic [15:0]          line_pitch;
    logic [ROW_CNT_W-1:0] rows;
    logic [7:0]           keep;
  } draw_cfg_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic [31:0]      addr;
    logic [7:0]       font_byte;
  } cmd_t;

endpackage

/* hdl/bfr_ram.sv */
// Generic simple dual-port RAM with registered read.
module bfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bfr_queue.sv */
// Two-entry command queue between the front end and the drawing back end.
module bfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bfr_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bfr_pkg::cmd_t pop_data_o
);
  import bfr_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* hdl/bfr_front.sv */
// Front end: config registers, cursor, item classification and address setup.
module bfr_front #(
  parameter int unsigned GLYPH_STORE_DEPTH = bfr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MAX_GLYPH_ROWS    = bfr_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bfr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [bfr_pkg::MODE_W-1:0]      s_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output bfr_pkg::cmd_t                   cmd_o,
  output bfr_pkg::draw_cfg_t              draw_cfg_o
);
  import bfr_pkg::*;

  localparam int unsigned AW         = $clog2(GLYPH_STORE_DEPTH);
  localparam int unsigned RED_W      = 24;
  // Glyph base stays below 2^14, store depth is at least 2^8
  localparam int unsigned FOLD_STEPS = 6;

  // Reduce a store index modulo the store depth by conditional subtracts
  function automatic logic [RED_W-1:0] fold(input logic [RED_W-1:0] v);
    logic [RED_W-1:0] r;
    logic [RED_W-1:0] m;
    int               k;
    r = v;
    for (k = FOLD_STEPS - 1; k >= 0; k--) begin
      m = RED_W'(GLYPH_STORE_DEPTH) << k;
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

  // Configuration
  logic [29:0] fb_base_q;
  logic [15:0] line_pitch_q;
  logic [8:0]  glyph_count_q;
  logic [5:0]  glyph_height_q;
  logic [3:0]  glyph_width_q;
  logic [5:0]  glyph_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q      <= 30'd0;
      line_pitch_q   <= 16'd4096;
      glyph_count_q  <= 9'd256;
      glyph_height_q <= 6'd16;
      glyph_width_q  <= 4'd8;
      glyph_bytes_q  <= 6'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FB_BASE:      fb_base_q      <= cfg_data_i;
        CFG_LINE_PITCH:   line_pitch_q   <= cfg_data_i[15:0];
        CFG_GLYPH_COUNT:  glyph_count_q  <= cfg_data_i[8:0];
        CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[5:0];
        CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data_i[3:0];
        CFG_GLYPH_BYTES:  glyph_bytes_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  logic [ROW_CNT_W-1:0] rows;
  logic [3:0]           width;
  logic [3:0]           cell_w;
  logic [7:0]           keep;

  always_comb begin
    rows = (glyph_height_q > MAX_GLYPH_ROWS) ? ROW_CNT_W'(MAX_GLYPH_ROWS) : glyph_height_q;
    if (glyph_width_q == 4'd0) begin
      width = 4'd1;
    end else if (glyph_width_q > 4'd8) begin
      width = 4'd8;
    end else begin
      width = glyph_width_q;
    end
    cell_w = width + 4'd1;
    keep   = 8'(8'hFF << (4'd8 - width));
  end

  assign draw_cfg_o = '{line_pitch: line_pitch_q, rows: rows, keep: keep};

  // Input item fields
  logic [MODE_W-1:0] in_mode;
  logic [7:0]        in_code;
  logic [15:0]       in_col, in_row;
  logic [11:0]       in_fidx;
  logic [7:0]        in_fbyte;
  logic              in_ctl, in_draw, in_keep, accept;

  assign in_mode  = s_axis_tuser;
  assign in_code  = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[23:8];
  assign in_row   = s_axis_tdata[39:24];
  assign in_fidx  = s_axis_tdata[51:40];
  assign in_fbyte = s_axis_tdata[59:52];

  assign in_ctl  = (in_code == CHAR_CR) || (in_code == CHAR_LF);
  assign in_draw = ((in_mode == MODE_PRINT) || (in_mode == MODE_DRAW)) && !in_ctl;
  // Drop items that leave no work for the back end
  assign in_keep = (in_mode == MODE_LOAD) || (in_draw && (rows != '0));
  assign accept  = s_axis_tvalid && s_axis_tready;

  // Cursor
  logic [15:0] cur_col_q, cur_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= 16'd0;
      cur_row_q <= 16'd0;
    end else if (accept) begin
      case (in_mode)
        MODE_PRINT: begin
          if (in_code == CHAR_CR) begin
            cur_col_q <= 16'd0;
          end else if (in_code == CHAR_LF) begin
            cur_col_q <= 16'd0;
            cur_row_q <= cur_row_q + 16'd1;
          end else begin
            cur_col_q <= cur_col_q + 16'd1;
          end
        end
        MODE_SET: begin
          cur_col_q <= in_col;
          cur_row_q <= in_row;
        end
        default: ;
      endcase
    end
  end

  // Three-stage setup pipeline
  logic a_v_q, b_v_q, c_v_q;
  logic en_a, en_b, en_c;

  assign en_c          = !c_v_q || cmd_ready_i;
  assign en_b          = !b_v_q || en_c;
  assign en_a          = !a_v_q || en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= accept && in_keep;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
    end
  end

  // Stage A: cell position and glyph number
  logic        a_load_q;
  logic [15:0] a_col_q, a_row_q;
  logic [7:0]  a_glyph_q;
  logic [11:0] a_fidx_q;
  logic [7:0]  a_fbyte_q;

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_load_q  <= (in_mode == MODE_LOAD);
      a_col_q   <= (in_mode == MODE_PRINT) ? cur_col_q : in_col;
      a_row_q   <= (in_mode == MODE_PRINT) ? cur_row_q : in_row;
      a_glyph_q <= ({1'b0, in_code} < glyph_count_q) ? in_code : 8'd0;
      a_fidx_q  <= in_fidx;
      a_fbyte_q <= in_fbyte;
    end
  end

  // Stage B: small products
  logic          b_load_q;
  logic [21:0]   b_rh_q;
  logic [19:0]   b_cw_q;
  logic [13:0]   b_gb_q;
  logic [AW-1:0] b_fidx_q;
  logic [7:0]    b_fbyte_q;
  logic [RED_W-1:0] fidx_fold;

  assign fidx_fold = fold(RED_W'(a_fidx_q));

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_load_q  <= a_load_q;
      b_rh_q    <= {6'd0, a_row_q} * {16'd0, rows};
      b_cw_q    <= {4'd0, a_col_q} * {16'd0, cell_w};
      b_gb_q    <= {6'd0, a_glyph_q} * {8'd0, glyph_bytes_q};
      b_fidx_q  <= fidx_fold[AW-1:0];
      b_fbyte_q <= a_fbyte_q;
    end
  end

  // Stage C: row offset, column offset and start index
  logic          c_load_q;
  logic [31:0]   c_rhp_q, c_offs_q;
  logic [AW-1:0] c_idx_q;
  logic [7:0]    c_fbyte_q;
  logic [37:0]   rhp_full;
  logic [RED_W-1:0] gb_fold;

  assign rhp_full = {16'd0, b_rh_q} * {22'd0, line_pitch_q};
  assign gb_fold  = fold(RED_W'(b_gb_q));

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_load_q  <= b_load_q;
      c_rhp_q   <= rhp_full[31:0];
      c_offs_q  <= 32'(fb_base_q) + 32'({b_cw_q, 2'b00});
      c_idx_q   <= b_load_q ? b_fidx_q : gb_fold[AW-1:0];
      c_fbyte_q <= b_fbyte_q;
    end
  end

  assign cmd_valid_o = c_v_q;
  assign cmd_o = '{load:      c_load_q,
                   idx:       IDX_W'(c_idx_q),
                   addr:      c_rhp_q + c_offs_q,
                   font_byte: c_fbyte_q};

endmodule

/* hdl/bfr_back.sv */
// Back end: glyph store, font loads and row-by-row glyph drawing.
module bfr_back #(
  parameter int unsigned GLYPH_STORE_DEPTH = bfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  bfr_pkg::cmd_t                   cmd_i,
  input  bfr_pkg::draw_cfg_t              draw_cfg_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);
  import bfr_pkg::*;

  localparam int unsigned AW = $clog2(GLYPH_STORE_DEPTH);

  logic                 busy_q;
  logic [ROW_CNT_W-1:0] left_q;
  logic [AW-1:0]        idx_q;
  logic [31:0]          addr_q;

  logic        s2_v_q, s2_last_q;
  logic [31:0] s2_addr_q;

  logic                  out_v_q, out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic       out_load, s2_free, issue, last_issue, pop, load_we;
  logic [7:0] rdata;

  assign out_load   = s2_v_q && (!out_v_q || m_axis_tready);
  assign s2_free    = !s2_v_q || out_load;
  assign issue      = busy_q && s2_free;
  assign last_issue = issue && (left_q == ROW_CNT_W'(1));
  // Take the next command as the last row of the current glyph issues
  assign cmd_ready_o = !busy_q || last_issue;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign load_we     = pop && cmd_i.load;

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_STORE_DEPTH)
  ) u_glyph_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cmd_i.idx[AW-1:0]),
    .wdata_i (cmd_i.font_byte),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop && !cmd_i.load) begin
        busy_q <= 1'b1;
      end else if (last_issue) begin
        busy_q <= 1'b0;
      end
      if (issue) begin
        s2_v_q <= 1'b1;
      end else if (out_load) begin
        s2_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !cmd_i.load) begin
      left_q <= draw_cfg_i.rows;
      idx_q  <= cmd_i.idx[AW-1:0];
      addr_q <= cmd_i.addr;
    end else if (issue) begin
      left_q <= left_q - ROW_CNT_W'(1);
      idx_q  <= (idx_q == AW'(GLYPH_STORE_DEPTH - 1)) ? '0 : idx_q + AW'(1);
      addr_q <= addr_q + 32'(draw_cfg_i.line_pitch);
    end
    if (issue) begin
      s2_addr_q <= addr_q;
      s2_last_q <= (left_q == ROW_CNT_W'(1));
    end
    if (out_load) begin
      out_data_q <= {rdata & draw_cfg_i.keep, s2_addr_q};
      out_last_q <= s2_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hdl/bitmap_font_text_renderer_top.sv */
// Bitmap font text renderer: front end, command queue and drawing back end.
// Throughput: a drawn glyph issues one row per cycle from the single read port of
// the glyph store while the output is not stalled; cursor items are dropped in the front end.
// Reset restores the config defaults, zeroes the cursor and empties the pipeline;
// the glyph store is not cleared and holds unknown data until loaded.
module bitmap_font_text_renderer_top #(
  parameter int unsigned GLYPH_STORE_DEPTH = bfr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MAX_GLYPH_ROWS    = bfr_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code[7:0], cell_column[23:8], cell_row[39:24], font_index[51:40],
  // font_byte[59:52], zero fill[63:60]
  input  logic [bfr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [bfr_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_address[31:0], row_bits[39:32]
  output logic [bfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bfr_pkg::*;

  logic      fe_valid, fe_ready, be_valid, be_ready;
  cmd_t      fe_cmd, be_cmd;
  draw_cfg_t draw_cfg;

  bfr_front #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH),
    .MAX_GLYPH_ROWS    (MAX_GLYPH_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_valid_o   (fe_valid),
    .cmd_ready_i   (fe_ready),
    .cmd_o         (fe_cmd),
    .draw_cfg_o    (draw_cfg)
  );

  bfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_cmd)
  );

  bfr_back #(
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (be_valid),
    .cmd_ready_o   (be_ready),
    .cmd_i         (be_cmd),
    .draw_cfg_i    (draw_cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
